// ----- rtl/bbv_pkg.sv -----
// ----------------------------------------------------------------------------
// bbv_pkg
// Shared types and constants for the bijective base-128 varint codec.
// ----------------------------------------------------------------------------
package bbv_pkg;

	localparam int SYM_W     = 64;             // symbol field width on the ports
	localparam int BYTE_W    = 8;
	localparam int MAX_BYTES = 10;             // longest encoding of one symbol
	localparam int CNT_W     = 4;              // byte counter while encoding
	localparam int POS_W     = 4;              // decode byte position, saturating
	localparam int TDATA_W   = SYM_W + BYTE_W;
	localparam int QDEPTH    = 2;

	typedef enum logic {
		MODE_ENC = 1'b0,
		MODE_DEC = 1'b1
	} mode_t;

	// one classified word waiting between front and back
	typedef struct packed {
		logic             dec;
		logic [SYM_W-1:0] data;   // masked symbol, or the byte zero-extended
	} qent_t;

	typedef struct packed {
		logic  valid;
		logic  full;
		qent_t head;
	} qstat_t;

endpackage

// ----- rtl/bbv_front.sv -----
// ----------------------------------------------------------------------------
// bbv_front
// Holds the mode register, accepts input words and tags each one as an
// encode or decode job for the queue.
// ----------------------------------------------------------------------------
module bbv_front #(
	parameter int SYMBOL_BITS = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wen,
	input  logic                        cfg_wdata,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [bbv_pkg::TDATA_W-1:0] s_axis_tdata,
	input  logic                        q_full,
	output logic                        q_push,
	output bbv_pkg::qent_t              q_ent
);

	localparam logic [bbv_pkg::SYM_W-1:0] SymMask =
		{bbv_pkg::SYM_W{1'b1}} >> (bbv_pkg::SYM_W - SYMBOL_BITS);

	bbv_pkg::mode_t mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= bbv_pkg::MODE_ENC;
		end else if (cfg_wen) begin
			mode_q <= bbv_pkg::mode_t'(cfg_wdata);
		end
	end

	assign s_axis_tready = !q_full;
	assign q_push        = s_axis_tvalid && !q_full;

	always_comb begin
		q_ent.dec = (mode_q == bbv_pkg::MODE_DEC);
		if (q_ent.dec) begin
			q_ent.data = bbv_pkg::SYM_W'(s_axis_tdata[bbv_pkg::TDATA_W-1:bbv_pkg::SYM_W]);
		end else begin
			q_ent.data = s_axis_tdata[bbv_pkg::SYM_W-1:0] & SymMask;
		end
	end

endmodule

// ----- rtl/bbv_queue.sv -----
// ----------------------------------------------------------------------------
// bbv_queue
// Two-entry FIFO decoupling the front from the back.
// ----------------------------------------------------------------------------
module bbv_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  bbv_pkg::qent_t  push_ent,
	input  logic            pop,
	output bbv_pkg::qstat_t stat
);

	localparam int PtrW = $clog2(bbv_pkg::QDEPTH);
	localparam int CntW = $clog2(bbv_pkg::QDEPTH + 1);

	bbv_pkg::qent_t ent_q [bbv_pkg::QDEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PtrW'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + CntW'(1);
				2'b01:   cnt_q <= cnt_q - CntW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_comb begin
		stat.valid = (cnt_q != '0);
		stat.full  = (cnt_q == CntW'(bbv_pkg::QDEPTH));
		stat.head  = ent_q[rd_ptr_q];
	end

endmodule

// ----- rtl/bbv_back.sv -----
// ----------------------------------------------------------------------------
// bbv_back
// Executes queued jobs: serializes a symbol into base-128 bytes one per
// cycle while the output is not stalled, or folds a byte into the decode
// accumulator. Drives the output register.
// ----------------------------------------------------------------------------
module bbv_back #(
	parameter int SYMBOL_BITS = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  bbv_pkg::qstat_t             q_stat,
	output logic                        q_pop,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [bbv_pkg::TDATA_W-1:0] m_axis_tdata,
	output logic                        m_axis_tlast
);

	localparam int SB = SYMBOL_BITS;
	localparam int CW = bbv_pkg::CNT_W;
	localparam int PW = bbv_pkg::POS_W;

	logic          enc_busy_q;
	logic [SB-1:0] s_q;
	logic [CW-1:0] n_q;
	logic [SB-1:0] acc_q;
	logic [PW-1:0] pos_q;

	logic          m_valid_q;
	logic [7:0]    out_byte_q;
	logic          out_last_q;
	logic [SB-1:0] out_sym_q;

	logic          out_free;
	logic [SB-1:0] cur_s;
	logic [CW-1:0] cur_n;
	logic          enc_more;
	logic [SB-1:0] enc_next;
	logic [7:0]    enc_byte;
	logic          enc_step;
	logic [7:0]    dec_byte;
	logic [6:0]    shamt;
	logic [SB-1:0] term;
	logic [SB-1:0] dec_sum;
	logic          dec_done;
	logic          dec_pop;

	always_comb begin
		out_free = !m_valid_q || m_axis_tready;

		cur_s    = enc_busy_q ? s_q : q_stat.head.data[SB-1:0];
		cur_n    = enc_busy_q ? n_q : '0;
		enc_more = (cur_s[SB-1:7] != '0) && (cur_n < CW'(bbv_pkg::MAX_BYTES - 1));
		enc_next = (cur_s >> 7) - SB'(1);
		enc_byte = enc_more ? {1'b1, cur_s[6:0]} : cur_s[7:0];
		enc_step = out_free && (enc_busy_q || (q_stat.valid && !q_stat.head.dec));

		// weight 128^k; shifts past the accumulator width drop out
		dec_byte = q_stat.head.data[7:0];
		shamt    = 7'(pos_q) * 7'd7;
		term     = SB'(dec_byte) << shamt;
		dec_sum  = acc_q + term;
		dec_done = !dec_byte[7];
		dec_pop  = q_stat.valid && q_stat.head.dec && !enc_busy_q && (out_free || !dec_done);

		q_pop    = (enc_step && !enc_busy_q) || dec_pop;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enc_busy_q <= 1'b0;
			n_q        <= '0;
			acc_q      <= '0;
			pos_q      <= '0;
			m_valid_q  <= 1'b0;
		end else begin
			if (enc_step) begin
				enc_busy_q <= enc_more;
				n_q        <= cur_n + CW'(1);
			end
			if (dec_pop) begin
				if (dec_done) begin
					acc_q <= '0;
					pos_q <= '0;
				end else begin
					acc_q <= dec_sum;
					if (pos_q != '1) begin
						pos_q <= pos_q + PW'(1);
					end
				end
			end
			if (out_free) begin
				m_valid_q <= enc_step || (dec_pop && dec_done);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (enc_step) begin
			s_q <= enc_next;
		end
		if (out_free) begin
			if (enc_step) begin
				out_byte_q <= enc_byte;
				out_last_q <= !enc_more;
				out_sym_q  <= '0;
			end else begin
				out_byte_q <= '0;
				out_last_q <= 1'b0;
				out_sym_q  <= dec_sum;
			end
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {bbv_pkg::SYM_W'(out_sym_q), out_byte_q};

`ifndef NO_ASSERTIONS
	a_busy_count: assert property (@(posedge clk) disable iff (!arst_n)
		enc_busy_q |-> (n_q != '0 && n_q < CW'(bbv_pkg::MAX_BYTES)))
		else $error("encode byte count out of range while busy");

	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		enc_busy_q |-> !q_pop)
		else $error("queue popped during encode serialization");

	a_enc_sym_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && out_last_q) |-> (out_sym_q == '0))
		else $error("encoded word carries a nonzero symbol");

	a_dec_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(dec_pop && dec_done) |=> (acc_q == '0 && pos_q == '0))
		else $error("decoder state not cleared after symbol end");
`endif

endmodule

// ----- rtl/bijective_base128_varint_codec_top.sv -----
// ----------------------------------------------------------------------------
// bijective_base128_varint_codec_top
// Encode: a symbol yields 1 to 10 bytes, one per cycle unless the output stalls;
//   the first byte goes through the queue, then the output register; the next symbol follows.
// Decode: one byte per cycle unless the queue or output stalls; a symbol word is valid once
//   its closing byte has gone through the queue write, then the back end into the output register.
// arst_n clears the mode (encode), the queue, decoder state and output valid.
// ----------------------------------------------------------------------------
module bijective_base128_varint_codec_top #(
	parameter int SYMBOL_BITS = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wen,
	input  logic                        cfg_wdata,     // mode
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [bbv_pkg::TDATA_W-1:0] s_axis_tdata,  // symbol_in[63:0], byte_in[71:64]
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [bbv_pkg::TDATA_W-1:0] m_axis_tdata,  // byte_out[7:0], symbol_out[71:8]
	output logic                        m_axis_tlast   // last_byte
);

	logic            q_push;
	logic            q_pop;
	bbv_pkg::qent_t  q_ent;
	bbv_pkg::qstat_t q_stat;

	bbv_front #(
		.SYMBOL_BITS(SYMBOL_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wen      (cfg_wen),
		.cfg_wdata    (cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.q_full       (q_stat.full),
		.q_push       (q_push),
		.q_ent        (q_ent)
	);

	bbv_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_ent(q_ent),
		.pop     (q_pop),
		.stat    (q_stat)
	);

	bbv_back #(
		.SYMBOL_BITS(SYMBOL_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_stat       (q_stat),
		.q_pop        (q_pop),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

endmodule
